>>> hdl/romaji_suffix_kana_converter_assert.svh
// Assertion macros shared by the converter RTL.
`ifndef ROMAJI_SUFFIX_KANA_CONVERTER_ASSERT_SVH
`define ROMAJI_SUFFIX_KANA_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define RSKC_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("rskc assertion failed");
`define RSKC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("rskc assertion failed");
`else
`define RSKC_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define RSKC_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

>>> hdl/rskc_pkg.sv
`default_nettype none
package rskc_pkg;

	localparam int INPUT_CHARS  = 8;
	localparam int APPEND_SLOTS = 6;
	localparam int KEY_CHARS    = 4;
	localparam int KANA_CHARS   = 3;
	localparam int ROM_COUNT    = 317;
	localparam int ROM_AW       = 9;

	typedef logic [15:0] char_t;

	// key holds the romaji right-justified: byte 0 is the key's last character
	typedef struct packed {
		logic                        weak_key;
		logic [2:0]                  klen;
		logic [8*KEY_CHARS-1:0]      key;
		logic [1:0]                  nkana;
		char_t [KANA_CHARS-1:0]      kana;
	} rom_entry_t;

	typedef struct packed {
		logic       use_strong;
		logic [2:0] skip;
		logic [3:0] avail;
	} probe_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_PASS1 = 4'b0010,
		ST_PASS2 = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	function automatic rom_entry_t k1(input logic [2:0] l, input logic [31:0] s,
		input char_t a);
		return '{1'b0, l, s, 2'd1, {16'h0000, 16'h0000, a}};
	endfunction

	function automatic rom_entry_t k2(input logic [2:0] l, input logic [31:0] s,
		input char_t a, input char_t b);
		return '{1'b0, l, s, 2'd2, {16'h0000, b, a}};
	endfunction

	function automatic rom_entry_t k3(input logic [2:0] l, input logic [31:0] s,
		input char_t a, input char_t b, input char_t c);
		return '{1'b0, l, s, 2'd3, {c, b, a}};
	endfunction

	function automatic rom_entry_t kw(input logic [2:0] l, input logic [31:0] s,
		input char_t a);
		return '{1'b1, l, s, 2'd1, {16'h0000, 16'h0000, a}};
	endfunction

	localparam rom_entry_t ROM [ROM_COUNT] = '{
		k2(3'd3,"vya",16'h3094,16'h3083), k2(3'd3,"vyi",16'h3094,16'h3043),
		k2(3'd3,"vyu",16'h3094,16'h3085), k2(3'd3,"vye",16'h3094,16'h3047),
		k2(3'd3,"vyo",16'h3094,16'h3087),
		k2(3'd3,"wwa",16'h3063,16'h308f), k3(3'd3,"wwi",16'h3063,16'h3046,16'h3043),
		k2(3'd3,"wwu",16'h3063,16'h3046), k3(3'd3,"wwe",16'h3063,16'h3046,16'h3047),
		k2(3'd3,"wwo",16'h3063,16'h3092),
		k2(3'd4,"wwyi",16'h3063,16'h3090), k2(3'd4,"wwye",16'h3063,16'h3091),
		k3(3'd4,"wwha",16'h3063,16'h3046,16'h3041),
		k3(3'd4,"wwhi",16'h3063,16'h3046,16'h3043),
		k2(3'd4,"wwhu",16'h3063,16'h3046),
		k3(3'd4,"wwhe",16'h3063,16'h3046,16'h3047),
		k3(3'd4,"wwho",16'h3063,16'h3046,16'h3049),
		k2(3'd3,"kya",16'h304d,16'h3083), k2(3'd3,"kyi",16'h304d,16'h3043),
		k2(3'd3,"kyu",16'h304d,16'h3085), k2(3'd3,"kye",16'h304d,16'h3047),
		k2(3'd3,"kyo",16'h304d,16'h3087),
		k2(3'd3,"gya",16'h304e,16'h3083), k2(3'd3,"gyi",16'h304e,16'h3043),
		k2(3'd3,"gyu",16'h304e,16'h3085), k2(3'd3,"gye",16'h304e,16'h3047),
		k2(3'd3,"gyo",16'h304e,16'h3087),
		k2(3'd3,"sya",16'h3057,16'h3083), k2(3'd3,"syi",16'h3057,16'h3043),
		k2(3'd3,"syu",16'h3057,16'h3085), k2(3'd3,"sye",16'h3057,16'h3047),
		k2(3'd3,"syo",16'h3057,16'h3087),
		k2(3'd3,"sha",16'h3057,16'h3083), k1(3'd3,"shi",16'h3057),
		k2(3'd3,"shu",16'h3057,16'h3085), k2(3'd3,"she",16'h3057,16'h3047),
		k2(3'd3,"sho",16'h3057,16'h3087),
		k2(3'd3,"zya",16'h3058,16'h3083), k2(3'd3,"zyi",16'h3058,16'h3043),
		k2(3'd3,"zyu",16'h3058,16'h3085), k2(3'd3,"zye",16'h3058,16'h3047),
		k2(3'd3,"zyo",16'h3058,16'h3087),
		k2(3'd3,"tya",16'h3061,16'h3083), k2(3'd3,"tyi",16'h3061,16'h3043),
		k2(3'd3,"tyu",16'h3061,16'h3085), k2(3'd3,"tye",16'h3061,16'h3047),
		k2(3'd3,"tyo",16'h3061,16'h3087),
		k2(3'd3,"cha",16'h3061,16'h3083), k1(3'd3,"chi",16'h3061),
		k2(3'd3,"chu",16'h3061,16'h3085), k2(3'd3,"che",16'h3061,16'h3047),
		k2(3'd3,"cho",16'h3061,16'h3087),
		k2(3'd3,"cya",16'h3061,16'h3083), k2(3'd3,"cyi",16'h3061,16'h3043),
		k2(3'd3,"cyu",16'h3061,16'h3085), k2(3'd3,"cye",16'h3061,16'h3047),
		k2(3'd3,"cyo",16'h3061,16'h3087),
		k2(3'd3,"dya",16'h3062,16'h3083), k2(3'd3,"dyi",16'h3062,16'h3043),
		k2(3'd3,"dyu",16'h3062,16'h3085), k2(3'd3,"dye",16'h3062,16'h3047),
		k2(3'd3,"dyo",16'h3062,16'h3087),
		k2(3'd3,"tsa",16'h3064,16'h3041), k2(3'd3,"tsi",16'h3064,16'h3043),
		k2(3'd3,"tse",16'h3064,16'h3047), k2(3'd3,"tso",16'h3064,16'h3049),
		k2(3'd3,"tha",16'h3066,16'h3083), k2(3'd3,"thi",16'h3066,16'h3043),
		k2(3'd3,"t'i",16'h3066,16'h3043), k2(3'd3,"thu",16'h3066,16'h3085),
		k2(3'd3,"the",16'h3066,16'h3047), k2(3'd3,"tho",16'h3066,16'h3087),
		k2(3'd4,"t'yu",16'h3066,16'h3085),
		k2(3'd3,"dha",16'h3067,16'h3083), k2(3'd3,"dhi",16'h3067,16'h3043),
		k2(3'd3,"d'i",16'h3067,16'h3043), k2(3'd3,"dhu",16'h3067,16'h3085),
		k2(3'd3,"dhe",16'h3067,16'h3047), k2(3'd3,"dho",16'h3067,16'h3087),
		k2(3'd4,"d'yu",16'h3067,16'h3085),
		k2(3'd3,"twa",16'h3068,16'h3041), k2(3'd3,"twi",16'h3068,16'h3043),
		k2(3'd3,"twu",16'h3068,16'h3045), k2(3'd3,"twe",16'h3068,16'h3047),
		k2(3'd3,"two",16'h3068,16'h3049), k2(3'd3,"t'u",16'h3068,16'h3045),
		k2(3'd3,"dwa",16'h3069,16'h3041), k2(3'd3,"dwi",16'h3069,16'h3043),
		k2(3'd3,"dwu",16'h3069,16'h3045), k2(3'd3,"dwe",16'h3069,16'h3047),
		k2(3'd3,"dwo",16'h3069,16'h3049), k2(3'd3,"d'u",16'h3069,16'h3045),
		k2(3'd3,"nya",16'h306b,16'h3083), k2(3'd3,"nyi",16'h306b,16'h3043),
		k2(3'd3,"nyu",16'h306b,16'h3085), k2(3'd3,"nye",16'h306b,16'h3047),
		k2(3'd3,"nyo",16'h306b,16'h3087),
		k2(3'd3,"hya",16'h3072,16'h3083), k2(3'd3,"hyi",16'h3072,16'h3043),
		k2(3'd3,"hyu",16'h3072,16'h3085), k2(3'd3,"hye",16'h3072,16'h3047),
		k2(3'd3,"hyo",16'h3072,16'h3087),
		k2(3'd3,"bya",16'h3073,16'h3083), k2(3'd3,"byi",16'h3073,16'h3043),
		k2(3'd3,"byu",16'h3073,16'h3085), k2(3'd3,"bye",16'h3073,16'h3047),
		k2(3'd3,"byo",16'h3073,16'h3087),
		k2(3'd3,"pya",16'h3074,16'h3083), k2(3'd3,"pyi",16'h3074,16'h3043),
		k2(3'd3,"pyu",16'h3074,16'h3085), k2(3'd3,"pye",16'h3074,16'h3047),
		k2(3'd3,"pyo",16'h3074,16'h3087),
		k2(3'd3,"fya",16'h3075,16'h3083), k2(3'd3,"fyu",16'h3075,16'h3085),
		k2(3'd3,"fyo",16'h3075,16'h3087),
		k2(3'd3,"hwa",16'h3075,16'h3041), k2(3'd3,"hwi",16'h3075,16'h3043),
		k2(3'd3,"hwe",16'h3075,16'h3047), k2(3'd3,"hwo",16'h3075,16'h3049),
		k2(3'd4,"hwyu",16'h3075,16'h3085),
		k2(3'd3,"mya",16'h307f,16'h3083), k2(3'd3,"myi",16'h307f,16'h3043),
		k2(3'd3,"myu",16'h307f,16'h3085), k2(3'd3,"mye",16'h307f,16'h3047),
		k2(3'd3,"myo",16'h307f,16'h3087),
		k2(3'd3,"jya",16'h3058,16'h3083), k2(3'd3,"jyi",16'h3058,16'h3043),
		k2(3'd3,"jyu",16'h3058,16'h3085), k2(3'd3,"jye",16'h3058,16'h3047),
		k2(3'd3,"jyo",16'h3058,16'h3087),
		k2(3'd3,"rya",16'h308a,16'h3083), k2(3'd3,"ryi",16'h308a,16'h3043),
		k2(3'd3,"ryu",16'h308a,16'h3085), k2(3'd3,"rye",16'h308a,16'h3047),
		k2(3'd3,"ryo",16'h308a,16'h3087),
		k1(3'd3,"xka",16'h30f5), k1(3'd3,"xke",16'h30f6),
		k1(3'd3,"lka",16'h30f5), k1(3'd3,"lke",16'h30f6),
		k1(3'd3,"lyi",16'h3043), k1(3'd3,"xyi",16'h3043),
		k1(3'd3,"lye",16'h3047), k1(3'd3,"xye",16'h3047),
		k2(3'd3,"kwa",16'h304f,16'h3041), k2(3'd3,"kwi",16'h304f,16'h3043),
		k2(3'd3,"kwe",16'h304f,16'h3047), k2(3'd3,"kwo",16'h304f,16'h3049),
		k2(3'd3,"gwa",16'h3050,16'h3041),
		k1(3'd3,"xtu",16'h3063), k1(3'd4,"xtsu",16'h3063),
		k1(3'd3,"ltu",16'h3063), k1(3'd4,"ltsu",16'h3063),
		k2(3'd3,"wha",16'h3046,16'h3041), k2(3'd3,"whi",16'h3046,16'h3043),
		k1(3'd3,"whu",16'h3046), k2(3'd3,"whe",16'h3046,16'h3047),
		k2(3'd3,"who",16'h3046,16'h3049),
		k1(3'd3,"xwa",16'h308e), k1(3'd3,"lwa",16'h308e), k1(3'd3,"xya",16'h3083),
		k1(3'd3,"lya",16'h3083), k1(3'd3,"wye",16'h3091),
		k1(3'd3,"xyo",16'h3087), k1(3'd3,"lyo",16'h3087), k1(3'd3,"wyi",16'h3090),
		k1(3'd3,"xyu",16'h3085), k1(3'd3,"lyu",16'h3085), k1(3'd3,"tsu",16'h3064),
		k1(3'd2,"z/",16'h30fb), k1(3'd2,"z.",16'h2026), k1(3'd2,"z,",16'h2025),
		k1(3'd2,"zh",16'h2190), k1(3'd2,"zj",16'h2193), k1(3'd2,"zk",16'h2191),
		k1(3'd2,"zl",16'h2192),
		k1(3'd2,"z-",16'h301c), k1(3'd2,"z[",16'h300e), k1(3'd2,"z]",16'h300f),
		k1(3'd1,"[",16'h300c), k1(3'd1,"]",16'h300d),
		k2(3'd2,"va",16'h3094,16'h3041), k2(3'd2,"vi",16'h3094,16'h3043),
		k1(3'd2,"vu",16'h3094), k2(3'd2,"ve",16'h3094,16'h3047),
		k2(3'd2,"vo",16'h3094,16'h3049),
		k2(3'd2,"qq",16'h3063,16'h0071), k2(3'd2,"vv",16'h3063,16'h0076),
		k2(3'd2,"ll",16'h3063,16'h006c), k2(3'd2,"xx",16'h3063,16'h0078),
		k2(3'd2,"kk",16'h3063,16'h006b), k2(3'd2,"gg",16'h3063,16'h0067),
		k2(3'd2,"ss",16'h3063,16'h0073), k2(3'd2,"zz",16'h3063,16'h007a),
		k2(3'd2,"jj",16'h3063,16'h006a), k2(3'd2,"tt",16'h3063,16'h0074),
		k2(3'd2,"dd",16'h3063,16'h0064), k2(3'd2,"hh",16'h3063,16'h0068),
		k2(3'd2,"ff",16'h3063,16'h0066), k2(3'd2,"bb",16'h3063,16'h0062),
		k2(3'd2,"pp",16'h3063,16'h0070), k2(3'd2,"mm",16'h3063,16'h006d),
		k2(3'd2,"yy",16'h3063,16'h0079), k2(3'd2,"rr",16'h3063,16'h0072),
		k2(3'd2,"fa",16'h3075,16'h3041), k2(3'd2,"fi",16'h3075,16'h3043),
		k1(3'd2,"fu",16'h3075), k2(3'd2,"fe",16'h3075,16'h3047),
		k2(3'd2,"fo",16'h3075,16'h3049),
		k1(3'd2,"nn",16'h3093), k1(3'd2,"xn",16'h3093),
		k1(3'd2,"xa",16'h3041), k1(3'd2,"xi",16'h3043), k1(3'd2,"xu",16'h3045),
		k1(3'd2,"xe",16'h3047), k1(3'd2,"xo",16'h3049),
		k1(3'd2,"la",16'h3041), k1(3'd2,"li",16'h3043), k1(3'd2,"lu",16'h3045),
		k1(3'd2,"le",16'h3047), k1(3'd2,"lo",16'h3049),
		k2(3'd2,"ye",16'h3044,16'h3047),
		k1(3'd2,"ka",16'h304b), k1(3'd2,"ki",16'h304d), k1(3'd2,"ku",16'h304f),
		k1(3'd2,"ke",16'h3051), k1(3'd2,"ko",16'h3053),
		k1(3'd2,"ga",16'h304c), k1(3'd2,"gi",16'h304e), k1(3'd2,"gu",16'h3050),
		k1(3'd2,"ge",16'h3052), k1(3'd2,"go",16'h3054),
		k1(3'd2,"sa",16'h3055), k1(3'd2,"si",16'h3057), k1(3'd2,"su",16'h3059),
		k1(3'd2,"se",16'h305b), k1(3'd2,"so",16'h305d),
		k1(3'd2,"ca",16'h304b), k1(3'd2,"ci",16'h3057), k1(3'd2,"cu",16'h304f),
		k1(3'd2,"ce",16'h305b), k1(3'd2,"co",16'h3053),
		k2(3'd2,"qa",16'h304f,16'h3041), k2(3'd2,"qi",16'h304f,16'h3043),
		k1(3'd2,"qu",16'h304f), k2(3'd2,"qe",16'h304f,16'h3047),
		k2(3'd2,"qo",16'h304f,16'h3049),
		k1(3'd2,"za",16'h3056), k1(3'd2,"zi",16'h3058), k1(3'd2,"zu",16'h305a),
		k1(3'd2,"ze",16'h305c), k1(3'd2,"zo",16'h305e),
		k2(3'd2,"ja",16'h3058,16'h3083), k1(3'd2,"ji",16'h3058),
		k2(3'd2,"ju",16'h3058,16'h3085), k2(3'd2,"je",16'h3058,16'h3047),
		k2(3'd2,"jo",16'h3058,16'h3087),
		k1(3'd2,"ta",16'h305f), k1(3'd2,"ti",16'h3061), k1(3'd2,"tu",16'h3064),
		k1(3'd2,"te",16'h3066), k1(3'd2,"to",16'h3068),
		k1(3'd2,"da",16'h3060), k1(3'd2,"di",16'h3062), k1(3'd2,"du",16'h3065),
		k1(3'd2,"de",16'h3067), k1(3'd2,"do",16'h3069),
		k1(3'd2,"na",16'h306a), k1(3'd2,"ni",16'h306b), k1(3'd2,"nu",16'h306c),
		k1(3'd2,"ne",16'h306d), k1(3'd2,"no",16'h306e),
		k1(3'd2,"ha",16'h306f), k1(3'd2,"hi",16'h3072), k1(3'd2,"hu",16'h3075),
		k1(3'd2,"fu",16'h3075), k1(3'd2,"he",16'h3078), k1(3'd2,"ho",16'h307b),
		k1(3'd2,"ba",16'h3070), k1(3'd2,"bi",16'h3073), k1(3'd2,"bu",16'h3076),
		k1(3'd2,"be",16'h3079), k1(3'd2,"bo",16'h307c),
		k1(3'd2,"pa",16'h3071), k1(3'd2,"pi",16'h3074), k1(3'd2,"pu",16'h3077),
		k1(3'd2,"pe",16'h307a), k1(3'd2,"po",16'h307d),
		k1(3'd2,"ma",16'h307e), k1(3'd2,"mi",16'h307f), k1(3'd2,"mu",16'h3080),
		k1(3'd2,"me",16'h3081), k1(3'd2,"mo",16'h3082),
		k1(3'd2,"ya",16'h3084), k1(3'd2,"yu",16'h3086), k1(3'd2,"yo",16'h3088),
		k1(3'd2,"ra",16'h3089), k1(3'd2,"ri",16'h308a), k1(3'd2,"ru",16'h308b),
		k1(3'd2,"re",16'h308c), k1(3'd2,"ro",16'h308d),
		k1(3'd2,"wa",16'h308f), k2(3'd2,"wi",16'h3046,16'h3043),
		k2(3'd2,"we",16'h3046,16'h3047), k1(3'd2,"wo",16'h3092),
		k2(3'd2,"cc",16'h3063,16'h0063),
		k1(3'd1,"a",16'h3042), k1(3'd1,"i",16'h3044), k1(3'd1,"u",16'h3046),
		k1(3'd2,"wu",16'h3046), k1(3'd1,"e",16'h3048), k1(3'd1,"o",16'h304a),
		k1(3'd2,"n'",16'h3093), kw(3'd1,"n",16'h3093),
		k1(3'd1,"-",16'h30fc), k1(3'd1,"~",16'h301c), k1(3'd1,".",16'h3002),
		k1(3'd1,",",16'h3001)
	};

	function automatic rom_entry_t rom_read(input logic [ROM_AW-1:0] addr);
		rom_entry_t e;
		e = '0;
		if (int'(addr) < ROM_COUNT) begin
			e = ROM[addr];
		end
		return e;
	endfunction

endpackage
`default_nettype wire

>>> hdl/rskc_in_if.sv
`default_nettype none
interface rskc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] tail_char_0;
	logic [15:0] tail_char_1;
	logic [15:0] tail_char_2;
	logic [15:0] tail_char_3;
	logic [15:0] tail_char_4;
	logic [15:0] tail_char_5;
	logic [15:0] tail_char_6;
	logic [15:0] tail_char_7;
	logic [3:0]  tail_length;
	logic        is_strong;

	modport source (output valid, tail_char_0, tail_char_1, tail_char_2, tail_char_3,
		tail_char_4, tail_char_5, tail_char_6, tail_char_7, tail_length, is_strong,
		input ready);
	modport sink (input valid, tail_char_0, tail_char_1, tail_char_2, tail_char_3,
		tail_char_4, tail_char_5, tail_char_6, tail_char_7, tail_length, is_strong,
		output ready);
endinterface
`default_nettype wire

>>> hdl/rskc_out_if.sv
`default_nettype none
interface rskc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  drop_count;
	logic [15:0] new_char_0;
	logic [15:0] new_char_1;
	logic [15:0] new_char_2;
	logic [15:0] new_char_3;
	logic [15:0] new_char_4;
	logic [15:0] new_char_5;
	logic [2:0]  new_count;

	modport source (output valid, drop_count, new_char_0, new_char_1, new_char_2,
		new_char_3, new_char_4, new_char_5, new_count, input ready);
	modport sink (input valid, drop_count, new_char_0, new_char_1, new_char_2,
		new_char_3, new_char_4, new_char_5, new_count, output ready);
endinterface
`default_nettype wire

>>> hdl/rskc_match.sv
`default_nettype none
// Compares one ROM key against the window end starting at probe.skip.
module rskc_match #(
	parameter int MAX_KEY_LEN = 4
) (
	input  rskc_pkg::rom_entry_t                        entry,
	input  rskc_pkg::char_t [rskc_pkg::INPUT_CHARS-1:0] win,
	input  rskc_pkg::probe_t                            probe,
	output logic                                        hit
);

	logic [3:0] pos;

	always_comb begin
		pos = 4'd0;
		hit = 1'b1;
		if (entry.weak_key && !probe.use_strong) begin
			hit = 1'b0;
		end
		if (entry.klen == 3'd0 || int'(entry.klen) > MAX_KEY_LEN ||
			{1'b0, entry.klen} > probe.avail) begin
			hit = 1'b0;
		end
		for (int m = 0; m < rskc_pkg::KEY_CHARS; m++) begin
			pos = {1'b0, probe.skip} + 4'(m);
			if (3'(m) < entry.klen) begin
				if (pos[3] || win[pos[2:0]] != {8'h00, entry.key[8*m +: 8]}) begin
					hit = 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/romaji_suffix_kana_converter.sv
// Romaji suffix to kana converter. A beat on tail carries the last characters of a
// composition string (tail_char_0 is the last) with its length and the strong flag;
// the block answers with one edit beat: drop_count characters to remove from the end
// and new_count characters to append. The key ROM is walked in table order, one entry
// per cycle through a single compare unit; the first key equal to the string end wins.
// Weak keys (the lone n) count only in strong mode. After a non-strong hit a second,
// strong walk runs on the characters in front of the key, and its kana comes first.
// The ROM walk sets the time an item takes; it runs once, or twice after a non-strong hit.
// tail is not ready while an item is in flight or its edit waits to be taken.
`default_nettype none
`include "romaji_suffix_kana_converter_assert.svh"
module romaji_suffix_kana_converter #(
	parameter int TABLE_ENTRIES = 512,
	parameter int MAX_KEY_LEN   = 4,
	parameter int MAX_OUT_LEN   = 3,
	parameter int WINDOW_LEN    = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rskc_in_if.sink   tail,
	rskc_out_if.source edit
);

	// entries actually walked
	localparam int LIMIT   = (TABLE_ENTRIES < rskc_pkg::ROM_COUNT) ?
		TABLE_ENTRIES : rskc_pkg::ROM_COUNT;
	localparam int IDX_W   = $clog2(LIMIT + 1);
	// length clamp and kana truncation
	localparam int LEN_CAP = (WINDOW_LEN < rskc_pkg::INPUT_CHARS) ?
		WINDOW_LEN : rskc_pkg::INPUT_CHARS;
	localparam int OUT_CAP = (MAX_OUT_LEN < rskc_pkg::KANA_CHARS) ?
		MAX_OUT_LEN : rskc_pkg::KANA_CHARS;

	rskc_pkg::state_t state_q;
	rskc_pkg::char_t [rskc_pkg::INPUT_CHARS-1:0] win_q;
	logic [3:0]       len_q;
	logic             strong_q;
	logic [IDX_W-1:0] idx_q;

	// ROM read stage
	rskc_pkg::rom_entry_t entry_s1;
	logic                 vld_s1;

	// first hit, kept across the prefix walk
	logic [2:0]       k1_q;
	logic [1:0]       n1_q;
	rskc_pkg::char_t [rskc_pkg::KANA_CHARS-1:0] kana1_q;

	// edit beat
	logic [3:0]       drop_q;
	rskc_pkg::char_t [rskc_pkg::APPEND_SLOTS-1:0] newc_q;
	logic [2:0]       newn_q;

	rskc_pkg::probe_t probe;
	logic             match;
	logic             hit_s1;
	logic             walk_end;
	logic             in_walk;

	// finishing values
	logic             f_hit1;
	logic [2:0]       f_k1;
	logic [1:0]       f_n1;
	rskc_pkg::char_t [rskc_pkg::KANA_CHARS-1:0] f_kana1;
	logic [2:0]       f_k2;
	logic [1:0]       f_n2;
	logic [2:0]       f_j;
	logic [3:0]       f_drop;
	rskc_pkg::char_t [rskc_pkg::APPEND_SLOTS-1:0] f_chars;
	logic [2:0]       f_n;

	function automatic logic [1:0] trunc_kana(input logic [1:0] n);
		return (int'(n) > OUT_CAP) ? 2'(OUT_CAP) : n;
	endfunction

	// the shared compare unit; the second walk is always strong
	always_comb begin
		probe.use_strong = strong_q;
		probe.skip       = 3'd0;
		probe.avail      = len_q;
		if (state_q == rskc_pkg::ST_PASS2) begin
			probe.use_strong = 1'b1;
			probe.skip       = k1_q;
			probe.avail      = len_q - {1'b0, k1_q};
		end
	end

	rskc_match #(
		.MAX_KEY_LEN (MAX_KEY_LEN)
	) u_match (
		.entry (entry_s1),
		.win   (win_q),
		.probe (probe),
		.hit   (match)
	);

	assign in_walk  = (state_q == rskc_pkg::ST_PASS1) || (state_q == rskc_pkg::ST_PASS2);
	assign hit_s1   = vld_s1 && match;
	assign walk_end = !vld_s1 && (idx_q == IDX_W'(LIMIT));

	// edit assembly: prefix kana first, then the kana of the first hit, six at most
	always_comb begin
		f_hit1  = 1'b1;
		f_k1    = k1_q;
		f_n1    = n1_q;
		f_kana1 = kana1_q;
		f_k2    = 3'd0;
		f_n2    = 2'd0;
		if (state_q == rskc_pkg::ST_PASS1) begin
			f_hit1  = hit_s1;
			f_k1    = entry_s1.klen;
			f_n1    = trunc_kana(entry_s1.nkana);
			f_kana1 = entry_s1.kana;
		end else if (hit_s1) begin
			f_k2 = entry_s1.klen;
			f_n2 = trunc_kana(entry_s1.nkana);
		end
		f_drop  = f_hit1 ? ({1'b0, f_k1} + {1'b0, f_k2}) : 4'd0;
		f_n     = f_hit1 ? ({1'b0, f_n1} + {1'b0, f_n2}) : 3'd0;
		f_j     = 3'd0;
		f_chars = '0;
		for (int k = 0; k < rskc_pkg::APPEND_SLOTS; k++) begin
			f_j = 3'(k) - {1'b0, f_n2};
			if (!f_hit1) begin
				f_chars[k] = '0;
			end else if (3'(k) < {1'b0, f_n2}) begin
				f_chars[k] = entry_s1.kana[k % rskc_pkg::KANA_CHARS];
			end else if (3'(k) >= {1'b0, f_n2} && f_j < {1'b0, f_n1}) begin
				f_chars[k] = f_kana1[f_j[1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rskc_pkg::ST_IDLE;
			vld_s1  <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				rskc_pkg::ST_IDLE: begin
					if (tail.valid) begin
						idx_q   <= '0;
						vld_s1  <= 1'b0;
						state_q <= rskc_pkg::ST_PASS1;
					end
				end
				rskc_pkg::ST_PASS1, rskc_pkg::ST_PASS2: begin
					if (hit_s1 && state_q == rskc_pkg::ST_PASS1 && !strong_q) begin
						// restart the walk for the prefix
						idx_q   <= '0;
						vld_s1  <= 1'b0;
						state_q <= rskc_pkg::ST_PASS2;
					end else if (hit_s1 || walk_end) begin
						vld_s1  <= 1'b0;
						state_q <= rskc_pkg::ST_DONE;
					end else if (idx_q != IDX_W'(LIMIT)) begin
						vld_s1 <= 1'b1;
						idx_q  <= idx_q + IDX_W'(1);
					end else begin
						vld_s1 <= 1'b0;
					end
				end
				rskc_pkg::ST_DONE: begin
					if (edit.ready) begin
						state_q <= rskc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rskc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == rskc_pkg::ST_IDLE && tail.valid) begin
			win_q    <= {tail.tail_char_7, tail.tail_char_6, tail.tail_char_5,
				tail.tail_char_4, tail.tail_char_3, tail.tail_char_2,
				tail.tail_char_1, tail.tail_char_0};
			len_q    <= (tail.tail_length > 4'(LEN_CAP)) ? 4'(LEN_CAP) : tail.tail_length;
			strong_q <= tail.is_strong;
		end
		if (in_walk) begin
			entry_s1 <= rskc_pkg::rom_read(rskc_pkg::ROM_AW'(idx_q));
		end
		if (state_q == rskc_pkg::ST_PASS1 && hit_s1) begin
			k1_q    <= entry_s1.klen;
			n1_q    <= trunc_kana(entry_s1.nkana);
			kana1_q <= entry_s1.kana;
		end
		if (in_walk && (hit_s1 || walk_end)) begin
			drop_q <= f_drop;
			newc_q <= f_chars;
			newn_q <= f_n;
		end
	end

	assign tail.ready      = (state_q == rskc_pkg::ST_IDLE);
	assign edit.valid      = (state_q == rskc_pkg::ST_DONE);
	assign edit.drop_count = drop_q;
	assign edit.new_char_0 = newc_q[0];
	assign edit.new_char_1 = newc_q[1];
	assign edit.new_char_2 = newc_q[2];
	assign edit.new_char_3 = newc_q[3];
	assign edit.new_char_4 = newc_q[4];
	assign edit.new_char_5 = newc_q[5];
	assign edit.new_count  = newn_q;

	`RSKC_ASSERT_IMP(a_no_overlap, clk, arst_n, tail.ready, !edit.valid)
	`RSKC_ASSERT_IMP(a_drop_iff_kana, clk, arst_n, edit.valid, (drop_q == 4'd0) == (newn_q == 3'd0))
	`RSKC_ASSERT_NEXT(a_accept_walks, clk, arst_n, tail.valid && tail.ready, state_q == rskc_pkg::ST_PASS1)
	`RSKC_ASSERT_NEXT(a_prefix_walk, clk, arst_n, hit_s1 && !probe.use_strong, state_q == rskc_pkg::ST_PASS2)

endmodule
`default_nettype wire

>>> sim/rskc_edit_checker.sv
`default_nettype none
module rskc_edit_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	rskc_in_if        tail,
	rskc_out_if       edit,
	output int        mismatches,
	output int        pending,
	output int        edits_seen,
	output int        hits_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]                                   drop;
		rskc_pkg::char_t [rskc_pkg::APPEND_SLOTS-1:0] chars;
		logic [2:0]                                   cnt;
	} kana_edit_t;

	kana_edit_t edits_due[$];

	// first ROM key equal to the string end that starts at window position skip
	function automatic int find_key(input rskc_pkg::char_t win[rskc_pkg::INPUT_CHARS],
		input int avail, input int skip, input bit strong_mode, output int klen);
		rskc_pkg::rom_entry_t e;
		int kl;
		bit hit;
		klen = 0;
		for (int i = 0; i < rskc_pkg::ROM_COUNT; i++) begin
			e = rskc_pkg::ROM[i];
			kl = 0;
			while (kl < rskc_pkg::KEY_CHARS && e.key[8*kl +: 8] != 8'h00) kl++;
			if (e.weak_key && !strong_mode) continue;
			if (kl == 0 || kl > avail) continue;
			hit = 1'b1;
			for (int j = 0; j < kl; j++) begin
				if (skip + j >= rskc_pkg::INPUT_CHARS ||
					win[skip + j] != {8'h00, e.key[8*j +: 8]})
					hit = 1'b0;
			end
			if (hit) begin
				klen = kl;
				return i;
			end
		end
		return -1;
	endfunction

	function automatic void add_kana(inout kana_edit_t r, input int idx);
		for (int j = 0; j < rskc_pkg::KANA_CHARS; j++) begin
			if (rskc_pkg::ROM[idx].kana[j] == 16'h0000) break;
			if (r.cnt < rskc_pkg::APPEND_SLOTS) begin
				r.chars[r.cnt] = rskc_pkg::ROM[idx].kana[j];
				r.cnt++;
			end
		end
	endfunction

	function automatic kana_edit_t kana_edit_of(input rskc_pkg::char_t win[rskc_pkg::INPUT_CHARS],
		input logic [3:0] tlen, input bit strong_mode);
		kana_edit_t r;
		int len, k1, k2, first, second;
		r = '0;
		len = (tlen > rskc_pkg::INPUT_CHARS) ? rskc_pkg::INPUT_CHARS : int'(tlen);
		first = find_key(win, len, 0, strong_mode, k1);
		if (first >= 0) begin
			r.drop = 4'(k1);
			if (!strong_mode) begin
				second = find_key(win, len - k1, k1, 1'b1, k2);
				if (second >= 0) begin
					r.drop = r.drop + 4'(k2);
					add_kana(r, second);
				end
			end
			add_kana(r, first);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rskc_pkg::char_t win[rskc_pkg::INPUT_CHARS];
		kana_edit_t got, want;
		if (!arst_n) begin
			edits_due.delete();
			mismatches <= 0;
			pending    <= 0;
			edits_seen <= 0;
			hits_seen  <= 0;
		end else begin
			if (tail.valid && tail.ready) begin
				win = '{tail.tail_char_0, tail.tail_char_1, tail.tail_char_2,
					tail.tail_char_3, tail.tail_char_4, tail.tail_char_5,
					tail.tail_char_6, tail.tail_char_7};
				edits_due.push_back(kana_edit_of(win, tail.tail_length, tail.is_strong));
			end
			if (edit.valid && edit.ready) begin
				got = {edit.drop_count, edit.new_char_5, edit.new_char_4, edit.new_char_3,
					edit.new_char_2, edit.new_char_1, edit.new_char_0, edit.new_count};
				edits_seen <= edits_seen + 1;
				if (got.drop != 0) hits_seen <= hits_seen + 1;
				if (edits_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected edit beat: drop %0d cnt %0d", got.drop, got.cnt);
					mismatches <= mismatches + 1;
				end else begin
					want = edits_due.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display({"edit mismatch: exp drop %0d cnt %0d chars %h, ",
								"got drop %0d cnt %0d chars %h"},
								want.drop, want.cnt, want.chars, got.drop, got.cnt, got.chars);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= edits_due.size();
		end
	end
endmodule
`default_nettype wire

>>> sim/romaji_suffix_kana_converter_test.sv
`default_nettype none
module romaji_suffix_kana_converter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_BEATS = 850;
	localparam string ROMAJI_CHARS = "aiueonnkstchyjwvxlzfgdbpmrq'-~.,[]/";

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches, pending, edits_seen, hits_seen;
	int   beats_sent = 0;
	int   idle_phase = 0;   // 0 none, 1 sender, 2 receiver, 3 both
	bit   hold_edit = 1'b0; // asks receiver for one long hold-off
	longint cycles = 0;

	rskc_in_if  tail();
	rskc_out_if edit();

	romaji_suffix_kana_converter DUT (.clk(clk), .arst_n(arst_n), .tail(tail), .edit(edit));

	rskc_edit_checker chk (.clk(clk), .arst_n(arst_n), .tail(tail), .edit(edit),
		.mismatches(mismatches), .pending(pending), .edits_seen(edits_seen),
		.hits_seen(hits_seen));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog - ends the run with an error once CYCLE_LIMIT is passed
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[romaji_suffix_kana_converter] ERROR");
			$finish;
		end
	end

	// receiver: random stalls by phase, plus one long counted hold-off on request
	initial begin
		int hold_cycles;
		edit.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_edit) begin
				edit.ready <= 1'b0;
				for (hold_cycles = 0; hold_cycles < 3000; hold_cycles++) @(posedge clk);
				hold_edit = 1'b0;
			end
			case (idle_phase)
				2: edit.ready <= ($urandom_range(99) >= 46);
				3: edit.ready <= ($urandom_range(99) >= 38);
				default: edit.ready <= 1'b1;
			endcase
		end
	end

	// one tail beat; char 0 is the string's last character
	task automatic send_beat(input rskc_pkg::char_t c[rskc_pkg::INPUT_CHARS],
		input logic [3:0] len, input bit strong_mode);
		int gap;
		gap = (idle_phase == 1) ? 46 : (idle_phase == 3) ? 38 : 0;
		while ($urandom_range(99) < gap) begin
			tail.valid <= 1'b0;
			@(posedge clk);
		end
		tail.valid       <= 1'b1;
		tail.tail_char_0 <= c[0];
		tail.tail_char_1 <= c[1];
		tail.tail_char_2 <= c[2];
		tail.tail_char_3 <= c[3];
		tail.tail_char_4 <= c[4];
		tail.tail_char_5 <= c[5];
		tail.tail_char_6 <= c[6];
		tail.tail_char_7 <= c[7];
		tail.tail_length <= len;
		tail.is_strong   <= strong_mode;
		// ready is stable mid-cycle; the beat goes at the following edge
		@(negedge clk);
		while (!tail.ready) @(negedge clk);
		@(posedge clk);
		beats_sent++;
	endtask

	// string written in reading order; padding past the length is noise
	task automatic send_text(input string s, input bit strong_mode);
		rskc_pkg::char_t c[rskc_pkg::INPUT_CHARS];
		int n;
		n = (s.len() > rskc_pkg::INPUT_CHARS) ? rskc_pkg::INPUT_CHARS : s.len();
		for (int k = 0; k < rskc_pkg::INPUT_CHARS; k++)
			c[k] = (k < n) ? rskc_pkg::char_t'(s[s.len() - 1 - k]) :
				rskc_pkg::char_t'($urandom);
		send_beat(c, 4'(n), strong_mode);
	endtask

	task automatic send_random();
		rskc_pkg::char_t c[rskc_pkg::INPUT_CHARS];
		logic [3:0] len;
		int pick;
		pick = $urandom_range(99);
		if (pick < 4) len = 4'd0;
		else if (pick < 12) len = 4'($urandom_range(15, 9));
		else len = 4'($urandom_range(8, 1));
		for (int k = 0; k < rskc_pkg::INPUT_CHARS; k++) begin
			if (pick >= 90 || $urandom_range(99) < 6) c[k] = rskc_pkg::char_t'($urandom);
			else c[k] = rskc_pkg::char_t'(ROMAJI_CHARS[$urandom_range(ROMAJI_CHARS.len() - 1)]);
		end
		send_beat(c, len, $urandom_range(3) == 0);
	endtask

	task automatic drain();
		tail.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		rskc_pkg::char_t ones[rskc_pkg::INPUT_CHARS];
		tail.valid = 1'b0;
		tail.tail_char_0 = '0; tail.tail_char_1 = '0; tail.tail_char_2 = '0;
		tail.tail_char_3 = '0; tail.tail_char_4 = '0; tail.tail_char_5 = '0;
		tail.tail_char_6 = '0; tail.tail_char_7 = '0;
		tail.tail_length = '0;
		tail.is_strong = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: simple hits, dangling n, weak n, longest keys and kana,
		// six appended characters, empty string, oversized length, all-ones chars
		send_text("ka", 1'b0);
		send_text("nka", 1'b0);
		send_text("n", 1'b0);
		send_text("n", 1'b1);
		send_text("nnka", 1'b1);
		send_text("kk", 1'b0);
		send_text("nn", 1'b0);
		send_text("n'", 1'b0);
		send_text("t'yu", 1'b0);
		send_text("wwha", 1'b0);
		send_text("nwwha", 1'b0);
		send_text("wwhawwha", 1'b0);
		send_text("wwhowwhe", 1'b1);
		send_text("z/", 1'b0);
		send_text(",", 1'b0);
		send_text("qqq", 1'b0);
		send_text("", 1'b0);
		send_text("xyz", 1'b0);
		for (int k = 0; k < rskc_pkg::INPUT_CHARS; k++) ones[k] = 16'hffff;
		send_beat(ones, 4'hf, 1'b1);
		ones[0] = rskc_pkg::char_t'("a");
		send_beat(ones, 4'hf, 1'b0);
		ones[0] = rskc_pkg::char_t'("a");
		ones[1] = rskc_pkg::char_t'("k");
		ones[2] = rskc_pkg::char_t'("n");
		send_beat(ones, 4'd2, 1'b0);
		drain();

		// random part in four idling phases
		for (int ph = 0; ph < 4; ph++) begin
			idle_phase = ph;
			for (int i = 0; i < RANDOM_BEATS / 4; i++) begin
				if (ph == 2 && i == 20) hold_edit = 1'b1;
				if (ph == 1 && i == 100) drain();
				send_random();
			end
		end
		drain();
		idle_phase = 0;
		repeat (700) @(posedge clk);

		$display("covered %0d tail beats, %0d edits checked, %0d with a key hit",
			beats_sent, edits_seen, hits_seen);
		if (mismatches == 0 && pending == 0)
			$display("[romaji_suffix_kana_converter] OK");
		else
			$display("[romaji_suffix_kana_converter] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
+incdir+hdl
hdl/rskc_pkg.sv
hdl/rskc_in_if.sv
hdl/rskc_out_if.sv
hdl/rskc_match.sv
hdl/romaji_suffix_kana_converter.sv
sim/rskc_edit_checker.sv
sim/romaji_suffix_kana_converter_test.sv
